// ===== src/tcw_pkg.sv =====
// Shared types, codes and constants for the text console writer.
package tcw_pkg;

  // Field widths of the request and response channels
  localparam int REQ_W  = 2;
  localparam int CHAR_W = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int LIN_W  = 11;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
  localparam logic [CHAR_W-1:0] FILL_CODE    = 8'h00;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUT   = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_SET   = 2'd2,
    REQ_READ  = 2'd3
  } req_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_PUT,
    ST_READ,
    ST_CLEAR,
    ST_SCROLL,
    ST_FLUSH,
    ST_FILL,
    ST_FINISH
  } state_e;

  // Grid write source selected by the controller
  typedef enum logic [1:0] {
    WR_NONE,
    WR_SPACE,
    WR_ZERO,
    WR_CHAR
  } wr_sel_e;

  typedef struct packed {
    logic    load_req;
    logic    calc_addr;
    logic    set_cur;
    logic    home_cur;
    logic    advance;
    wr_sel_e wr_sel;
    logic    cnt_clr;
    logic    cnt_inc;
    logic    copy_rd;
    logic    rd_cell;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    req_e req_type;
    logic wrap;
    logic copy_last;
    logic cnt_end;
    logic out_free;
  } sts_t;

endpackage

// ===== src/tcw_if.sv =====
// Request and response channel interfaces of the text console writer.
interface tcw_req_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [CHAR_W-1:0] char_code;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;

  modport source (output valid, req_type, char_code, col, row, input ready);
  modport sink   (input valid, req_type, char_code, col, row, output ready);
endinterface

interface tcw_rsp_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [COL_W-1:0]  cursor_col;
  logic [ROW_W-1:0]  cursor_row;
  logic [LIN_W-1:0]  cursor_linear;
  logic              serial_valid;
  logic [CHAR_W-1:0] serial_byte;
  logic [CHAR_W-1:0] cell_data;

  modport source (output valid, cursor_col, cursor_row, cursor_linear, serial_valid,
                  serial_byte, cell_data, input ready);
  modport sink   (input valid, cursor_col, cursor_row, cursor_linear, serial_valid,
                  serial_byte, cell_data, output ready);
endinterface

// ===== src/text_console_writer.sv =====
// Top level of the text console writer: controller plus datapath.
//
// Teletype-style console holding a COLUMNS x ROWS grid of character bytes
// and a cursor. Requests arrive on req_i (valid/ready); each one produces
// exactly one response on rsp_o (valid/ready) carrying the cursor after the
// request, its linear position row*COLUMNS+col, the serial echo of a put
// and the cell byte of a read.
// Steps per request after the accept in idle:
//   put character / read cell : decode, put or read, finish
//   set cursor                : decode, finish
//   clear screen              : decode, clear (one cell written per cycle), finish
//   put that scrolls          : decode, put, scroll (copy of ROWS-1 rows at one
//                               cell per cycle), flush, fill (bottom row
//                               zero-filled), finish
// Short requests step through the controller's state sequence; clear and
// scroll sweep the grid through its single write port, one cell per cycle.
// The response is loaded into the output register in the finish step.
// Reset: the cursor goes home and a clearing pass writes spaces over the
// grid while req_i.ready is low.
// Stall: the response sits in an output register; the next request is taken
// meanwhile and waits at its final step until the register is free.
module text_console_writer import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tcw_req_if.sink     req_i,
  tcw_rsp_if.source   rsp_o
);

  cmd_t cmd;
  sts_t sts;

  tcw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_type_i      (req_i.req_type),
    .char_code_i     (req_i.char_code),
    .col_i           (req_i.col),
    .row_i           (req_i.row),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .rsp_valid_o     (rsp_o.valid),
    .rsp_ready_i     (rsp_o.ready),
    .cursor_col_o    (rsp_o.cursor_col),
    .cursor_row_o    (rsp_o.cursor_row),
    .cursor_linear_o (rsp_o.cursor_linear),
    .serial_valid_o  (rsp_o.serial_valid),
    .serial_byte_o   (rsp_o.serial_byte),
    .cell_data_o     (rsp_o.cell_data)
  );

endmodule

// ===== src/tcw_ctrl.sv =====
// Controller state machine of the text console writer.
module tcw_ctrl import tcw_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (sts_i.cnt_end) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        unique case (sts_i.req_type)
          REQ_PUT:   state_d = ST_PUT;
          REQ_CLEAR: state_d = ST_CLEAR;
          REQ_SET:   state_d = ST_FINISH;
          REQ_READ:  state_d = ST_READ;
          default:   state_d = ST_FINISH;
        endcase
      end
      ST_PUT: begin
        state_d = sts_i.wrap ? ST_SCROLL : ST_FINISH;
      end
      ST_READ:  state_d = ST_FINISH;
      ST_CLEAR: begin
        if (sts_i.cnt_end) state_d = ST_FINISH;
      end
      ST_SCROLL: begin
        if (sts_i.copy_last) state_d = ST_FLUSH;
      end
      ST_FLUSH: state_d = ST_FILL;
      ST_FILL: begin
        if (sts_i.cnt_end) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_INIT;
    endcase
  end

  // Commands
  always_comb begin
    req_ready_o     = 1'b0;
    cmd_o.load_req  = 1'b0;
    cmd_o.calc_addr = 1'b0;
    cmd_o.set_cur   = 1'b0;
    cmd_o.home_cur  = 1'b0;
    cmd_o.advance   = 1'b0;
    cmd_o.wr_sel    = WR_NONE;
    cmd_o.cnt_clr   = 1'b0;
    cmd_o.cnt_inc   = 1'b0;
    cmd_o.copy_rd   = 1'b0;
    cmd_o.rd_cell   = 1'b0;
    cmd_o.load_out  = 1'b0;
    unique case (state_q)
      ST_INIT, ST_CLEAR: begin
        cmd_o.wr_sel  = WR_SPACE;
        cmd_o.cnt_inc = 1'b1;
      end
      ST_IDLE: begin
        req_ready_o    = 1'b1;
        cmd_o.load_req = req_valid_i;
      end
      ST_DECODE: begin
        cmd_o.calc_addr = 1'b1;
        cmd_o.cnt_clr   = 1'b1;
        cmd_o.set_cur   = (sts_i.req_type == REQ_SET);
        cmd_o.home_cur  = (sts_i.req_type == REQ_CLEAR);
      end
      ST_PUT: begin
        cmd_o.wr_sel  = WR_CHAR;
        cmd_o.advance = 1'b1;
      end
      ST_READ: cmd_o.rd_cell = 1'b1;
      ST_SCROLL: begin
        cmd_o.copy_rd = 1'b1;
        cmd_o.cnt_inc = 1'b1;
      end
      ST_FLUSH: ;
      ST_FILL: begin
        cmd_o.wr_sel  = WR_ZERO;
        cmd_o.cnt_inc = 1'b1;
      end
      ST_FINISH: cmd_o.load_out = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

// ===== src/tcw_datapath.sv =====
// Datapath of the text console writer: cursor, character grid and result register.
module tcw_datapath import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [REQ_W-1:0]  req_type_i,
  input  logic [CHAR_W-1:0] char_code_i,
  input  logic [COL_W-1:0]  col_i,
  input  logic [ROW_W-1:0]  row_i,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output logic [COL_W-1:0]  cursor_col_o,
  output logic [ROW_W-1:0]  cursor_row_o,
  output logic [LIN_W-1:0]  cursor_linear_o,
  output logic              serial_valid_o,
  output logic [CHAR_W-1:0] serial_byte_o,
  output logic [CHAR_W-1:0] cell_data_o
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int AW    = $clog2(CELLS);
  localparam int CLW   = (CW > COL_W) ? CW : COL_W;
  localparam int RLW   = (RW > ROW_W) ? RW : ROW_W;

  function automatic logic [AW-1:0] lin_addr(logic [RW-1:0] r, logic [CW-1:0] c);
    return AW'(r) * AW'(COLUMNS) + AW'(c);
  endfunction

  req_e              req_type_q;
  logic [CHAR_W-1:0] char_q;
  logic [CW-1:0]     col_c_q;
  logic [RW-1:0]     row_c_q;
  logic [AW-1:0]     addr_q;
  logic [CW-1:0]     cur_col_q;
  logic [RW-1:0]     cur_row_q;
  logic [AW-1:0]     cnt_q;
  logic              cp_vld_q;
  logic [AW-1:0]     cp_dst_q;
  logic [CHAR_W-1:0] rdata_q;
  logic              out_valid_q;
  logic [COL_W-1:0]  out_col_q;
  logic [ROW_W-1:0]  out_row_q;
  logic [LIN_W-1:0]  out_lin_q;
  logic              out_ser_vld_q;
  logic [CHAR_W-1:0] out_ser_byte_q;
  logic [CHAR_W-1:0] out_cell_q;

  logic [CHAR_W-1:0] grid_q [CELLS];

  logic [CW-1:0] col_clamp;
  logic [RW-1:0] row_clamp;
  logic          is_nl, col_end, row_end, line_end;
  logic [AW-1:0] rd_addr;
  logic          we;
  logic [AW-1:0] wa;
  logic [CHAR_W-1:0] wd;

  // Out-of-range coordinates clamp to the last column / row
  assign col_clamp = (CLW'(col_i) > CLW'(COLUMNS - 1)) ? CW'(COLUMNS - 1) : CW'(col_i);
  assign row_clamp = (RLW'(row_i) > RLW'(ROWS - 1))    ? RW'(ROWS - 1)    : RW'(row_i);

  // Cursor advance after a put
  assign is_nl    = (char_q == NEWLINE_CODE);
  assign col_end  = (cur_col_q == CW'(COLUMNS - 1));
  assign row_end  = (cur_row_q == RW'(ROWS - 1));
  assign line_end = is_nl || col_end;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_type_q <= req_e'(req_type_i);
      char_q     <= char_code_i;
      col_c_q    <= col_clamp;
      row_c_q    <= row_clamp;
    end
    if (cmd_i.calc_addr) begin
      addr_q <= (req_type_q == REQ_READ) ? lin_addr(row_c_q, col_c_q)
                                         : lin_addr(cur_row_q, cur_col_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_col_q <= '0;
      cur_row_q <= '0;
    end else if (cmd_i.home_cur) begin
      cur_col_q <= '0;
      cur_row_q <= '0;
    end else if (cmd_i.set_cur) begin
      cur_col_q <= col_c_q;
      cur_row_q <= row_c_q;
    end else if (cmd_i.advance) begin
      if (line_end) begin
        cur_col_q <= '0;
        cur_row_q <= row_end ? RW'(ROWS - 1) : cur_row_q + RW'(1);
      end else begin
        cur_col_q <= cur_col_q + CW'(1);
      end
    end
  end

  // Sweep counter and the copy pipeline of a scroll
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      cp_vld_q <= 1'b0;
    end else begin
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + AW'(1);
      end
      cp_vld_q <= cmd_i.copy_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.copy_rd) cp_dst_q <= cnt_q;
  end

  // Grid memory: one write and one registered read per cycle
  assign rd_addr = cmd_i.copy_rd ? cnt_q + AW'(COLUMNS) : addr_q;

  always_comb begin
    we = 1'b0;
    wa = cnt_q;
    wd = SPACE_CODE;
    if (cp_vld_q) begin
      we = 1'b1;
      wa = cp_dst_q;
      wd = rdata_q;
    end else begin
      case (cmd_i.wr_sel)
        WR_SPACE: we = 1'b1;
        WR_ZERO: begin
          we = 1'b1;
          wd = FILL_CODE;
        end
        WR_CHAR: begin
          we = !is_nl;
          wa = addr_q;
          wd = char_q;
        end
        default: we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) grid_q[wa] <= wd;
    if (cmd_i.copy_rd || cmd_i.rd_cell) rdata_q <= grid_q[rd_addr];
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_col_q      <= COL_W'(cur_col_q);
      out_row_q      <= ROW_W'(cur_row_q);
      out_lin_q      <= LIN_W'(lin_addr(cur_row_q, cur_col_q));
      out_ser_vld_q  <= (req_type_q == REQ_PUT);
      out_ser_byte_q <= (req_type_q == REQ_PUT) ? char_q : '0;
      out_cell_q     <= (req_type_q == REQ_READ) ? rdata_q : '0;
    end
  end

  assign sts_o.req_type  = req_type_q;
  assign sts_o.wrap      = line_end && row_end;
  assign sts_o.copy_last = (cnt_q == AW'(CELLS - COLUMNS - 1));
  assign sts_o.cnt_end   = (cnt_q == AW'(CELLS - 1));
  assign sts_o.out_free  = !out_valid_q || rsp_ready_i;

  assign rsp_valid_o     = out_valid_q;
  assign cursor_col_o    = out_col_q;
  assign cursor_row_o    = out_row_q;
  assign cursor_linear_o = out_lin_q;
  assign serial_valid_o  = out_ser_vld_q;
  assign serial_byte_o   = out_ser_byte_q;
  assign cell_data_o     = out_cell_q;

  // A pending scroll copy owns the write port
  a_copy_write_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cp_vld_q |-> cmd_i.wr_sel == WR_NONE)
    else $error("grid write collides with scroll copy");

  a_cursor_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_col_q <= CW'(COLUMNS - 1) && cur_row_q <= RW'(ROWS - 1))
    else $error("cursor outside the grid");

  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !rsp_ready_i) |-> !cmd_i.load_out)
    else $error("pending result overwritten");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the text console writer: directed and random requests.
module tb;
  import tcw_pkg::*;

  // Screen geometry of the instance under test
  localparam int SCREEN_COLS = 80;
  localparam int SCREEN_ROWS = 25;
  localparam int CELLS       = SCREEN_COLS * SCREEN_ROWS;

  // Watchdog: a clean run stays well below this limit even if every request
  // scrolled under heavy receiver stalls.
  localparam int LIMIT_CYCLES = 10_000_000;
  // Settle time after the last response; every request, sweep or not, has
  // its own response.
  localparam int SETTLE_CYCLES = 40;
  localparam int REPORT_MAX    = 10;

  // One response as the console reports it
  typedef struct packed {
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic [LIN_W-1:0]  cursor_linear;
    logic              serial_valid;
    logic [CHAR_W-1:0] serial_byte;
    logic [CHAR_W-1:0] cell_data;
  } console_rsp_t;

  logic clk_i  = 1'b0;
  logic rst_ni;

  tcw_req_if req_if ();
  tcw_rsp_if rsp_if ();

  text_console_writer #(
    .COLUMNS(SCREEN_COLS),
    .ROWS   (SCREEN_ROWS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Console shadow: screen contents and cursor as the block should hold them
  // ---------------------------------------------------------------------------
  logic [CHAR_W-1:0] screen [0:CELLS-1];
  int                cur_col;
  int                cur_row;

  console_rsp_t awaited_rsp [$];   // responses owed by the block, oldest first
  int           fails     = 0;
  int           cycle_cnt = 0;
  int           hold_req;          // long receiver hold-off, picked up by the receiver
  int           burst_left;

  function automatic void fill_screen(logic [CHAR_W-1:0] code);
    for (int i = 0; i < CELLS; i++) screen[i] = code;
  endfunction

  // Applies one request to the shadow console and returns the response it owes.
  function automatic console_rsp_t console_apply(req_e kind, logic [CHAR_W-1:0] ch,
                                                 logic [COL_W-1:0] c, logic [ROW_W-1:0] r);
    console_rsp_t rsp;
    int           cc;
    int           rr;
    rsp = '0;
    // Out-of-range coordinates pin to the last column / row
    cc  = (c >= SCREEN_COLS) ? SCREEN_COLS - 1 : int'(c);
    rr  = (r >= SCREEN_ROWS) ? SCREEN_ROWS - 1 : int'(r);
    case (kind)
      REQ_PUT: begin
        rsp.serial_valid = 1'b1;
        rsp.serial_byte  = ch;
        // Newline is echoed but never stored
        if (ch != NEWLINE_CODE) begin
          screen[cur_row * SCREEN_COLS + cur_col] = ch;
          cur_col++;
        end
        if (ch == NEWLINE_CODE || cur_col >= SCREEN_COLS) begin
          cur_col = 0;
          cur_row++;
          // Past the last row: shift everything up, bottom row becomes zeros
          if (cur_row >= SCREEN_ROWS) begin
            for (int i = 0; i < CELLS - SCREEN_COLS; i++) screen[i] = screen[i + SCREEN_COLS];
            for (int i = CELLS - SCREEN_COLS; i < CELLS; i++) screen[i] = FILL_CODE;
            cur_row = SCREEN_ROWS - 1;
          end
        end
      end
      REQ_CLEAR: begin
        fill_screen(SPACE_CODE);
        cur_col = 0;
        cur_row = 0;
      end
      REQ_SET: begin
        cur_col = cc;
        cur_row = rr;
      end
      default: begin
        // Read leaves the cursor alone
        rsp.cell_data = screen[rr * SCREEN_COLS + cc];
      end
    endcase
    rsp.cursor_col    = COL_W'(cur_col);
    rsp.cursor_row    = ROW_W'(cur_row);
    rsp.cursor_linear = LIN_W'(cur_row * SCREEN_COLS + cur_col);
    return rsp;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  // Offers one request and returns at the edge that accepts it. valid stays
  // high into the next call unless a gap is taken here, so back-to-back
  // requests never drop valid. Bursts of random length, random gaps between.
  task automatic send_req(input req_e kind, input logic [CHAR_W-1:0] ch,
                          input logic [COL_W-1:0] c, input logic [ROW_W-1:0] r);
    int gap;
    req_if.valid     <= 1'b1;
    req_if.req_type  <= kind;
    req_if.char_code <= ch;
    req_if.col       <= c;
    req_if.row       <= r;
    do @(posedge clk_i); while (!req_if.ready);
    awaited_rsp.push_back(console_apply(kind, ch, c, r));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      gap        = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 9);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Sender goes quiet until every owed response has come back
  task automatic wait_drain();
    req_if.valid <= 1'b0;
    while (awaited_rsp.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Response side: stall pattern plus checking of every accepted response
  // ---------------------------------------------------------------------------
  initial begin
    int           hold_left;
    int           mode;
    int           mode_left;
    int           phase;
    console_rsp_t got;
    console_rsp_t want;
    hold_left     = 0;
    mode          = 0;
    mode_left     = 0;
    phase         = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready) begin
        got = '{rsp_if.cursor_col, rsp_if.cursor_row, rsp_if.cursor_linear,
                rsp_if.serial_valid, rsp_if.serial_byte, rsp_if.cell_data};
        if (awaited_rsp.size() == 0) begin
          fails++;
          if (fails <= REPORT_MAX)
            $display("unexpected response: col %0d row %0d lin %0d ser %0b/%02h cell %02h",
                     got.cursor_col, got.cursor_row, got.cursor_linear,
                     got.serial_valid, got.serial_byte, got.cell_data);
        end else begin
          want = awaited_rsp.pop_front();
          if (got !== want) begin
            fails++;
            if (fails <= REPORT_MAX) begin
              $display("response mismatch at cycle %0d", cycle_cnt);
              $display("  exp: col %0d row %0d lin %0d ser %0b/%02h cell %02h",
                       want.cursor_col, want.cursor_row, want.cursor_linear,
                       want.serial_valid, want.serial_byte, want.cell_data);
              $display("  got: col %0d row %0d lin %0d ser %0b/%02h cell %02h",
                       got.cursor_col, got.cursor_row, got.cursor_linear,
                       got.serial_valid, got.serial_byte, got.cell_data);
            end
          end
        end
      end
      // Long hold-off asked by a test takes priority over the normal pattern
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 120);
      end else begin
        mode_left--;
      end
      phase = (phase + 1) % 4;
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        case (mode)
          0:       rsp_if.ready <= 1'b1;                          // no stalls
          1:       rsp_if.ready <= ($urandom_range(0, 1) == 0);   // heavy random stalls
          2:       rsp_if.ready <= (phase != 3);                  // one stall in four
          default: rsp_if.ready <= ($urandom_range(0, 9) != 0);   // light random stalls
        endcase
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Byte extremes, newline, set cursor with clamping, reads inside and beyond
  // the grid (read must not move the cursor).
  task automatic test_corners();
    send_req(REQ_READ, 8'h00, 7'd0, 5'd0);        // fresh screen reads as space
    send_req(REQ_PUT, 8'h00, 7'd0, 5'd0);
    send_req(REQ_PUT, 8'hFF, 7'h7F, 5'h1F);
    send_req(REQ_PUT, NEWLINE_CODE, 7'd0, 5'd0);  // echoed, not stored
    send_req(REQ_READ, 8'h00, 7'd1, 5'd0);
    send_req(REQ_READ, 8'h00, 7'd2, 5'd0);        // newline left the cell alone
    send_req(REQ_SET, 8'h00, 7'h7F, 5'h1F);       // clamps to last cell
    send_req(REQ_READ, 8'h00, 7'h7F, 5'h1F);
    send_req(REQ_SET, 8'h00, 7'd80, 5'd25);       // first out-of-range values
    send_req(REQ_SET, 8'h00, 7'd0, 5'd0);
    send_req(REQ_PUT, 8'h80, 7'd0, 5'd0);
    send_req(REQ_PUT, 8'h7F, 7'd0, 5'd0);
  endtask

  // Wrap at the right edge of the last row, newline on the last row, the
  // zero-filled bottom row after a scroll, then a clear.
  task automatic test_scroll_and_clear();
    send_req(REQ_SET, 8'h00, 7'd79, 5'd24);
    send_req(REQ_PUT, 8'h41, 7'd0, 5'd0);         // wrap on last row scrolls
    send_req(REQ_READ, 8'h00, 7'd79, 5'd23);
    send_req(REQ_READ, 8'h00, 7'd5, 5'd24);       // zero fill, not space
    send_req(REQ_PUT, 8'h42, 7'd0, 5'd0);
    send_req(REQ_PUT, NEWLINE_CODE, 7'd0, 5'd0);  // newline on last row scrolls
    send_req(REQ_READ, 8'h00, 7'd0, 5'd23);
    send_req(REQ_READ, 8'h00, 7'd0, 5'd0);
    send_req(REQ_CLEAR, 8'h00, 7'd0, 5'd0);
    send_req(REQ_READ, 8'h00, 7'd79, 5'd24);
    send_req(REQ_READ, 8'h00, 7'd0, 5'h1F);
  endtask

  // Receiver holds off for a long stretch while requests keep coming, so the
  // block fills up and drops ready; afterwards the sender waits out the drain.
  task automatic test_backpressure();
    hold_req = 600;
    for (int n = 0; n < 24; n++)
      send_req((n % 3 == 2) ? REQ_READ : REQ_PUT, CHAR_W'(8'h30 + n), 7'(n), 5'(n % 8));
    wait_drain();
  endtask

  // Text-like stream: mostly printable characters with newlines, some cursor
  // moves (often near the bottom-right corner so wraps scroll), reads close to
  // the cursor or anywhere, an occasional clear. Drains now and then.
  task automatic test_random_text(input int count);
    req_e              kind;
    logic [CHAR_W-1:0] ch;
    logic [COL_W-1:0]  c;
    logic [ROW_W-1:0]  r;
    int                pick;
    int                sel;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 999);
      sel  = $urandom_range(0, 99);
      ch   = CHAR_W'($urandom_range(0, 255));
      c    = COL_W'($urandom_range(0, 127));
      r    = ROW_W'($urandom_range(0, 31));
      if (pick < 700) begin
        kind = REQ_PUT;
        if (sel < 7)       ch = NEWLINE_CODE;
        else if (sel < 85) ch = CHAR_W'($urandom_range(8'h20, 8'h7E));
      end else if (pick < 800) begin
        kind = REQ_SET;
        if (sel < 25) begin
          c = COL_W'($urandom_range(72, 79));
          r = ROW_W'(SCREEN_ROWS - 1);
        end else if (sel < 60) begin
          c = COL_W'($urandom_range(0, SCREEN_COLS - 1));
          r = ROW_W'($urandom_range(0, SCREEN_ROWS - 1));
        end
      end else if (pick < 985) begin
        kind = REQ_READ;
        // Half the reads look at the cell just written
        if (sel < 50) begin
          c = (cur_col > 0) ? COL_W'(cur_col - 1) : '0;
          r = ROW_W'(cur_row);
        end
      end else begin
        kind = REQ_CLEAR;
      end
      send_req(kind, ch, c, r);
      if (n % 250 == 249) wait_drain();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    hold_req   = 0;
    burst_left = 0;
    cur_col    = 0;
    cur_row    = 0;
    fill_screen(SPACE_CODE);
    rst_ni           <= 1'b0;
    req_if.valid     <= 1'b0;
    req_if.req_type  <= REQ_PUT;
    req_if.char_code <= '0;
    req_if.col       <= '0;
    req_if.row       <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The block runs its clearing pass first; the handshake simply waits.
    test_corners();
    test_scroll_and_clear();
    test_backpressure();
    test_random_text(800);

    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fails == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/tcw_pkg.sv
src/tcw_if.sv
src/tcw_ctrl.sv
src/tcw_datapath.sv
src/text_console_writer.sv
tb/tb.sv
